[sv/dihd_pkg.sv]
// Shared types, constants and helpers for the dual-index Hamming demultiplexer.
// Used by the cell, the cell row, the counter store and the top level.
// No dependencies.
package dihd_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 128;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int INDEX_BASES = 8;
  localparam int BASE_W      = 8;
  localparam int BASES_W     = 64;

  // Field widths
  localparam int DIST_W      = 4;
  localparam int ECNT_W      = 8;
  localparam int MAXD_W      = 4;
  localparam int OUT_IDX_W   = 8;
  localparam int COUNT_W     = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  // Distance reported when no entry was searched
  localparam logic [DIST_W-1:0] NO_DISTANCE = DIST_W'(INDEX_BASES + 1);

  // Item commands
  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = CFG_IDX_W'(1);

  // Token handed from cell to cell: the item in flight and its running best
  typedef struct packed {
    logic                valid;
    logic                cmd;
    logic [IDX_W-1:0]    pos;
    logic [ECNT_W-1:0]   remaining;
    logic [IDX_W-1:0]    front_idx;
    logic [DIST_W-1:0]   front_dist;
    logic [IDX_W-1:0]    back_idx;
    logic [DIST_W-1:0]   back_dist;
  } token_t;

  // Count differing base bytes between two index words
  function automatic logic [DIST_W-1:0] base_mismatches(
    input logic [BASES_W-1:0] a,
    input logic [BASES_W-1:0] b
  );
    logic [DIST_W-1:0] d;
    d = '0;
    for (int i = 0; i < INDEX_BASES; i++) begin
      if (a[BASE_W*i +: BASE_W] != b[BASE_W*i +: BASE_W]) begin
        d = d + 1'b1;
      end
    end
    return d;
  endfunction

endpackage

[sv/dihd_cell.sv]
// One table cell: holds a front/back index pair and scores the passing token.
// Depends on dihd_pkg.
module dihd_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dihd_pkg::token_t            tok_i,
  input  logic [dihd_pkg::BASES_W-1:0] key_front,
  input  logic [dihd_pkg::BASES_W-1:0] key_back,
  input  logic [dihd_pkg::IDX_W-1:0]  load_slot,
  output dihd_pkg::token_t            tok_o
);

  logic [dihd_pkg::BASES_W-1:0] front_r;
  logic [dihd_pkg::BASES_W-1:0] back_r;
  dihd_pkg::token_t             tok_r;
  dihd_pkg::token_t             tok_nxt;
  logic [dihd_pkg::DIST_W-1:0]  d_front;
  logic [dihd_pkg::DIST_W-1:0]  d_back;
  logic                         score;
  logic                         load_hit;

  assign d_front  = dihd_pkg::base_mismatches(key_front, front_r);
  assign d_back   = dihd_pkg::base_mismatches(key_back, back_r);
  assign score    = tok_i.valid && (tok_i.cmd == dihd_pkg::CMD_CLASSIFY) &&
                    (tok_i.remaining != '0);
  assign load_hit = tok_i.valid && (tok_i.cmd == dihd_pkg::CMD_LOAD) &&
                    (tok_i.pos == load_slot);

  // Advance position, fold this entry into the running best
  always_comb begin
    tok_nxt     = tok_i;
    tok_nxt.pos = tok_i.pos + 1'b1;
    if (score) begin
      tok_nxt.remaining = tok_i.remaining - 1'b1;
      if (d_front < tok_i.front_dist) begin
        tok_nxt.front_dist = d_front;
        tok_nxt.front_idx  = tok_i.pos;
      end
      if (d_back < tok_i.back_dist) begin
        tok_nxt.back_dist = d_back;
        tok_nxt.back_idx  = tok_i.pos;
      end
    end
  end

  // Hand the token to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  // Store the pair when a load names this cell
  always_ff @(posedge clk) begin
    if (load_hit) begin
      front_r <= key_front;
      back_r  <= key_back;
    end
  end

  assign tok_o = tok_r;

endmodule

[sv/dihd_chain.sv]
// Row of table cells; a token enters at cell 0 and leaves after the last cell.
// Depends on dihd_pkg and dihd_cell.
module dihd_chain (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dihd_pkg::token_t            tok_i,
  input  logic [dihd_pkg::BASES_W-1:0] key_front,
  input  logic [dihd_pkg::BASES_W-1:0] key_back,
  input  logic [dihd_pkg::IDX_W-1:0]  load_slot,
  output dihd_pkg::token_t            tok_o
);

  dihd_pkg::token_t link [0:dihd_pkg::TABLE_DEPTH];

  assign link[0] = tok_i;

  // Build the row
  for (genvar i = 0; i < dihd_pkg::TABLE_DEPTH; i++) begin : g_cell
    dihd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .tok_i     (link[i]),
      .key_front (key_front),
      .key_back  (key_back),
      .load_slot (load_slot),
      .tok_o     (link[i+1])
    );
  end

  assign tok_o = link[dihd_pkg::TABLE_DEPTH];

endmodule

[sv/dihd_counters.sv]
// Per-entry saturating match counters: a memory with one valid bit per entry.
// Registered read, then increment and write back in the cycle after. Depends on dihd_pkg.
module dihd_counters (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        lookup_en,
  input  logic                        lookup_hit,
  input  logic [dihd_pkg::IDX_W-1:0]  lookup_idx,
  output logic                        done,
  output logic [dihd_pkg::COUNT_W-1:0] count
);

  logic [dihd_pkg::COUNT_W-1:0]     mem [0:dihd_pkg::TABLE_DEPTH-1];
  logic [dihd_pkg::TABLE_DEPTH-1:0] valid_r;
  logic [dihd_pkg::COUNT_W-1:0]     rd_r;
  logic                             vld_r;
  logic                             en_r;
  logic                             hit_r;
  logic [dihd_pkg::IDX_W-1:0]       idx_r;
  logic [dihd_pkg::COUNT_W-1:0]     cur;
  logic [dihd_pkg::COUNT_W-1:0]     upd;

  // Never-written entries read as zero; saturate at all ones
  assign cur   = vld_r ? rd_r : '0;
  assign upd   = (cur == '1) ? cur : cur + 1'b1;
  assign done  = en_r;
  assign count = hit_r ? upd : '0;

  // Control of the read/update pair
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r    <= 1'b0;
      hit_r   <= 1'b0;
      valid_r <= '0;
    end else begin
      en_r  <= lookup_en;
      hit_r <= lookup_en && lookup_hit;
      if (en_r && hit_r) begin
        valid_r[idx_r] <= 1'b1;
      end
    end
  end

  // Counter memory: registered read, write back the updated count
  always_ff @(posedge clk) begin
    if (lookup_en) begin
      rd_r  <= mem[lookup_idx];
      vld_r <= valid_r[lookup_idx];
      idx_r <= lookup_idx;
    end
    if (en_r && hit_r) begin
      mem[idx_r] <= upd;
    end
  end

endmodule

[sv/dual_index_hamming_demux_core.sv]
// Dual-index Hamming read demultiplexer, top level.
// Usage:
//   Items are presented on in_* with start; a transfer happens when start is
//   high and busy is low. A load (in_cmd = 0) stores in_front_bases and
//   in_back_bases into slot in_entry_index and gives no result. A classify
//   (in_cmd = 1) searches the first entry_count slots (at most TABLE_DEPTH) for
//   each end and gives one result on out_*, marked by out_valid for exactly one cycle.
//   Configuration: cfg_index selects entry_count (0) or max_distance (1);
//   cfg_ready is always high. Write only while busy is low.
// Timing:
//   Each item walks the row of TABLE_DEPTH cells, one cell per cycle. A
//   classify passes the launch register, the row, the counter read and
//   the result register before out_valid strobes. busy drops when a load
//   leaves the row or when the counter update of a classify is done.
//   One item is in flight at a time.
// Reset:
//   Synchronous, active low. Clears the match counters (through valid bits),
//   sets entry_count to 0 and max_distance to 2. Table slots hold no value
//   until loaded. The receiver cannot stall; results are never held.
module dual_index_hamming_demux_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_cmd,
  input  logic [dihd_pkg::IDX_W-1:0]        in_entry_index,
  input  logic [dihd_pkg::BASES_W-1:0]      in_front_bases,
  input  logic [dihd_pkg::BASES_W-1:0]      in_back_bases,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dihd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dihd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              out_valid,
  output logic signed [dihd_pkg::OUT_IDX_W-1:0] out_front_index,
  output logic signed [dihd_pkg::OUT_IDX_W-1:0] out_back_index,
  output logic [dihd_pkg::DIST_W-1:0]       out_front_distance,
  output logic [dihd_pkg::DIST_W-1:0]       out_back_distance,
  output logic                              out_matched,
  output logic [dihd_pkg::COUNT_W-1:0]      out_group_count
);

  logic                              accept;
  logic                              busy_r;
  logic                              busy_nxt;
  logic [dihd_pkg::ECNT_W-1:0]       entry_count_r;
  logic [dihd_pkg::MAXD_W-1:0]       max_distance_r;
  logic [dihd_pkg::BASES_W-1:0]      key_front_r;
  logic [dihd_pkg::BASES_W-1:0]      key_back_r;
  logic [dihd_pkg::IDX_W-1:0]        slot_r;
  dihd_pkg::token_t                  launch_r;
  dihd_pkg::token_t                  launch_nxt;
  dihd_pkg::token_t                  tail;
  logic [dihd_pkg::ECNT_W-1:0]       search_count;
  logic                              tail_classify;
  logic                              tail_load;
  logic                              front_found;
  logic                              back_found;
  logic                              tail_hit;
  logic [dihd_pkg::OUT_IDX_W-1:0]    res_front_idx_r;
  logic [dihd_pkg::OUT_IDX_W-1:0]    res_back_idx_r;
  logic [dihd_pkg::DIST_W-1:0]       res_front_dist_r;
  logic [dihd_pkg::DIST_W-1:0]       res_back_dist_r;
  logic                              res_hit_r;
  logic                              cnt_done;
  logic [dihd_pkg::COUNT_W-1:0]      cnt_value;
  logic                              out_valid_r;
  logic [dihd_pkg::OUT_IDX_W-1:0]    out_front_index_r;
  logic [dihd_pkg::OUT_IDX_W-1:0]    out_back_index_r;
  logic [dihd_pkg::DIST_W-1:0]       out_front_distance_r;
  logic [dihd_pkg::DIST_W-1:0]       out_back_distance_r;
  logic                              out_matched_r;
  logic [dihd_pkg::COUNT_W-1:0]      out_group_count_r;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  // Clamp the searched range to the table
  assign search_count = (entry_count_r > dihd_pkg::ECNT_W'(dihd_pkg::TABLE_DEPTH)) ?
                        dihd_pkg::ECNT_W'(dihd_pkg::TABLE_DEPTH) : entry_count_r;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r  <= '0;
      max_distance_r <= dihd_pkg::MAXD_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dihd_pkg::CFG_ENTRY_COUNT:  entry_count_r  <= cfg_data;
        dihd_pkg::CFG_MAX_DISTANCE: max_distance_r <= cfg_data[dihd_pkg::MAXD_W-1:0];
        default: ;
      endcase
    end
  end

  // Build the token that enters the row
  always_comb begin
    launch_nxt = '0;
    if (accept) begin
      launch_nxt.valid      = 1'b1;
      launch_nxt.cmd        = in_cmd;
      launch_nxt.remaining  = search_count;
      launch_nxt.front_dist = dihd_pkg::NO_DISTANCE;
      launch_nxt.back_dist  = dihd_pkg::NO_DISTANCE;
    end
  end

  // Busy from accept until the item leaves the block
  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (tail_load || cnt_done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      launch_r <= '0;
    end else begin
      busy_r   <= busy_nxt;
      launch_r <= launch_nxt;
    end
  end

  // Hold the item's keys; they double as load data
  always_ff @(posedge clk) begin
    if (accept) begin
      key_front_r <= in_front_bases;
      key_back_r  <= in_back_bases;
      slot_r      <= in_entry_index;
    end
  end

  dihd_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_i     (launch_r),
    .key_front (key_front_r),
    .key_back  (key_back_r),
    .load_slot (slot_r),
    .tok_o     (tail)
  );

  // Decide the match at the end of the row
  assign tail_classify = tail.valid && (tail.cmd == dihd_pkg::CMD_CLASSIFY);
  assign tail_load     = tail.valid && (tail.cmd == dihd_pkg::CMD_LOAD);
  assign front_found   = tail.front_dist != dihd_pkg::NO_DISTANCE;
  assign back_found    = tail.back_dist != dihd_pkg::NO_DISTANCE;
  assign tail_hit      = front_found && back_found &&
                         (tail.front_dist <= max_distance_r) &&
                         (tail.back_dist <= max_distance_r) &&
                         (tail.front_idx == tail.back_idx);

  // Capture the search result while the counter is read
  always_ff @(posedge clk) begin
    if (tail_classify) begin
      res_front_idx_r  <= front_found ? dihd_pkg::OUT_IDX_W'(tail.front_idx) : '1;
      res_back_idx_r   <= back_found ? dihd_pkg::OUT_IDX_W'(tail.back_idx) : '1;
      res_front_dist_r <= tail.front_dist;
      res_back_dist_r  <= tail.back_dist;
      res_hit_r        <= tail_hit;
    end
  end

  dihd_counters u_counters (
    .clk        (clk),
    .rst_n      (rst_n),
    .lookup_en  (tail_classify),
    .lookup_hit (tail_hit),
    .lookup_idx (tail.front_idx),
    .done       (cnt_done),
    .count      (cnt_value)
  );

  // Result register: strobe for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cnt_done;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_done) begin
      out_front_index_r    <= res_front_idx_r;
      out_back_index_r     <= res_back_idx_r;
      out_front_distance_r <= res_front_dist_r;
      out_back_distance_r  <= res_back_dist_r;
      out_matched_r        <= res_hit_r;
      out_group_count_r    <= cnt_value;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_front_index    = out_front_index_r;
  assign out_back_index     = out_back_index_r;
  assign out_front_distance = out_front_distance_r;
  assign out_back_distance  = out_back_distance_r;
  assign out_matched        = out_matched_r;
  assign out_group_count    = out_group_count_r;

endmodule
